### rtl/pca_pkg.sv
// Package for the point cluster assignment block: sizes, field widths, codes,
// the controller/datapath command and status structs and the store address function.
// Depends on nothing.
`default_nettype none

package pca_pkg;

    // Table geometry.
    localparam int MAX_CLUSTERS       = 128;
    localparam int POINTS_PER_CLUSTER = 128;
    localparam int STORE_DEPTH        = MAX_CLUSTERS * POINTS_PER_CLUSTER;

    localparam int CL_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CC_W   = $clog2(MAX_CLUSTERS + 1);
    localparam int SLOT_W = $clog2(POINTS_PER_CLUSTER);
    localparam int CNT_W  = $clog2(POINTS_PER_CLUSTER + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // Field widths.
    localparam int COORD_W = 16;
    localparam int COLOR_W = 2;
    localparam int TAG_W   = 9;
    localparam int IDX_W   = 7;
    localparam int OUTC_W  = 2;
    localparam int CFG_W   = 32;
    localparam int PT_W    = 2 * COORD_W + TAG_W;

    localparam logic [CFG_W-1:0] JOIN_DIST_SQ_RESET = 32'd10000;

    // Input commands.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Result outcome codes.
    localparam logic [OUTC_W-1:0] OUTC_JOINED  = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_OPENED  = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_DROPPED = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_CLEARED = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted transaction, restart at cluster 0
        logic cnt_rd;    // read the point count of the current cluster
        logic cnt_take;  // latch that count, restart the slot counter
        logic issue;     // read the next stored point of the current cluster
        logic next;      // move on to the next cluster
        logic do_join;   // store the point in the current cluster
        logic do_open;   // open a new cluster with the point
        logic do_drop;   // report a dropped point
        logic do_clear;  // empty the table
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;    // the captured command is a clear
        logic c_end;       // every existing cluster has been visited
        logic table_full;  // no unused cluster is left
        logic last_issue;  // the slot counter points at the last stored point
        logic pipe_busy;   // distance pipeline still holds reads
        logic found;       // a stored point of the current cluster is near
        logic out_busy;    // the result register cannot take a new result
    } t_status;

    function automatic logic [ADDR_W-1:0] f_store_addr(
        input logic [CL_W-1:0]   cluster,
        input logic [SLOT_W-1:0] slot
    );
        return ADDR_W'(cluster) * ADDR_W'(POINTS_PER_CLUSTER) + ADDR_W'(slot);
    endfunction

endpackage

`default_nettype wire

### rtl/pca_if.sv
// Channel interfaces of the point cluster assignment block: the point input
// channel and the result output channel. Depends on pca_pkg.
`default_nettype none

interface pca_in_if import pca_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [COLOR_W-1:0]        point_color;
    logic [TAG_W-1:0]          point_tag;

    modport source (output valid, command, point_x, point_y, point_color, point_tag,
                    input ready);
    modport sink   (input valid, command, point_x, point_y, point_color, point_tag,
                    output ready);
endinterface

interface pca_out_if import pca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  cluster_index;
    logic [IDX_W-1:0]  point_slot;
    logic [OUTC_W-1:0] outcome;
    logic              overwrote;

    modport source (output valid, cluster_index, point_slot, outcome, overwrote,
                    input ready);
    modport sink   (input valid, cluster_index, point_slot, outcome, overwrote,
                    output ready);
endinterface

`default_nettype wire

### rtl/point_cluster_assign_unit.sv
// Top level of the point cluster assignment block: channel interfaces, the
// threshold write port, controller and datapath. Depends on pca_pkg, pca_if,
// pca_ctrl and pca_datapath.
`default_nettype none

// Single-pass Euclidean clustering of 2-D points. Each add transaction carries a
// point in millimetres; the block walks the existing clusters in the order they
// were opened and the point joins the first cluster holding any stored point whose
// squared distance to it is strictly below the programmed join_dist_sq (reset
// value 10000, i.e. 100 mm). With no match the next unused cluster is opened; with
// the table full the point is dropped; a full cluster has its last slot
// overwritten and the result says so. A clear transaction empties the table for a
// new scan. Every input transaction yields exactly one result transaction.
// A clear, or an open into an empty table, is decided in the state after the
// accepting one, and its result is registered as the decision is made. An add
// otherwise reads the point count of each cluster visited, captures it, reads
// the stored points of that cluster and then drains the distance pipeline; the
// point memory has one read port and delivers one stored point per cycle. The
// walk stops at the first cluster with a near point, although up to three
// further stored points are read before the hit is seen, and the join then
// follows in its own state. A drop, or an open when no cluster matches, walks
// every existing cluster, so its cost grows with the clusters opened and the
// points stored; without clears between scans the stored points can grow to
// the whole store. A stalled result sink holds the block in its decision or
// join state. Only one transaction is in progress at a time; the next is
// accepted as soon as the previous one has produced its result, even while
// that result still waits in the output register. The point store (16384 entries)
// and the per-cluster count memory need no clearing pass after reset or clear:
// only clusters below the current cluster count are ever read, and opening a
// cluster writes its count and first point. The threshold should only be written
// while the block is idle.
module point_cluster_assign_unit import pca_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    pca_in_if.sink           i_pt,
    pca_out_if.source        o_res
);

    t_cmd    cmd;
    t_status status;

    pca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .o_in_ready (i_pt.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pca_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_command       (i_pt.command),
        .i_point_x       (i_pt.point_x),
        .i_point_y       (i_pt.point_y),
        .i_point_tag     (i_pt.point_tag),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_cluster_index (o_res.cluster_index),
        .o_point_slot    (o_res.point_slot),
        .o_outcome       (o_res.outcome),
        .o_overwrote     (o_res.overwrote)
    );

endmodule

`default_nettype wire

### rtl/pca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module pca_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/pca_datapath.sv
// Datapath of the point cluster assignment block: join threshold register,
// captured point, cluster counters, count and point memories, distance pipeline
// and result register. Depends on pca_pkg and pca_ram.
`default_nettype none

module pca_datapath import pca_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_W-1:0]          i_cfg_wr_data,
    input  logic                      i_command,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic [TAG_W-1:0]          i_point_tag,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [IDX_W-1:0]          o_cluster_index,
    output logic [IDX_W-1:0]          o_point_slot,
    output logic [OUTC_W-1:0]         o_outcome,
    output logic                      o_overwrote
);

    logic [CFG_W-1:0]          r_join_dist_sq;
    logic                      r_command;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic [TAG_W-1:0]          r_tag;

    logic [CC_W-1:0]   r_cluster, n_cluster;
    logic [CC_W-1:0]   r_ccount, n_ccount;
    logic [SLOT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0]  r_n;
    logic              r_found, n_found;

    logic              r_v1, r_v2, r_hit;
    logic [2*COORD_W-1:0] r_sqx, r_sqy;

    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [IDX_W-1:0]  r_out_slot;
    logic [OUTC_W-1:0] r_out_outcome;
    logic              r_out_over;

    logic              emit;
    logic              join_full;
    logic [SLOT_W-1:0] join_slot;
    logic [CNT_W-1:0]  join_cnt;
    logic [CNT_W-1:0]  cnt_rdata;
    logic [PT_W-1:0]   pt_rdata;
    logic [ADDR_W-1:0] pt_waddr;
    logic [ADDR_W-1:0] pt_raddr;

    logic signed [COORD_W-1:0]   rd_x, rd_y;
    logic signed [COORD_W:0]     dx, dy;
    logic signed [2*COORD_W+1:0] dx2, dy2;
    logic [2*COORD_W:0]          d2;

    // Slot and new count for a join; a full cluster keeps its count and
    // has its last slot overwritten.
    assign join_full = (r_n >= CNT_W'(POINTS_PER_CLUSTER));
    assign join_slot = join_full ? SLOT_W'(POINTS_PER_CLUSTER - 1) : r_n[SLOT_W-1:0];
    assign join_cnt  = join_full ? CNT_W'(POINTS_PER_CLUSTER) : r_n + CNT_W'(1);

    assign pt_waddr = f_store_addr(r_cluster[CL_W-1:0],
                                   i_cmd.do_open ? SLOT_W'(0) : join_slot);
    assign pt_raddr = f_store_addr(r_cluster[CL_W-1:0], r_k);

    pca_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CLUSTERS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.do_join | i_cmd.do_open),
        .i_waddr (r_cluster[CL_W-1:0]),
        .i_wdata (i_cmd.do_open ? CNT_W'(1) : join_cnt),
        .i_re    (i_cmd.cnt_rd),
        .i_raddr (r_cluster[CL_W-1:0]),
        .o_rdata (cnt_rdata)
    );

    pca_ram #(.WIDTH(PT_W), .DEPTH(STORE_DEPTH)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.do_join | i_cmd.do_open),
        .i_waddr (pt_waddr),
        .i_wdata ({r_px, r_py, r_tag}),
        .i_re    (i_cmd.issue),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    // Distance pipeline: memory read, squares, sum and compare.
    assign rd_x = pt_rdata[PT_W-1 -: COORD_W];
    assign rd_y = pt_rdata[TAG_W +: COORD_W];
    assign dx   = $signed({r_px[COORD_W-1], r_px}) - $signed({rd_x[COORD_W-1], rd_x});
    assign dy   = $signed({r_py[COORD_W-1], r_py}) - $signed({rd_y[COORD_W-1], rd_y});
    assign dx2  = dx * dx;
    assign dy2  = dy * dy;
    assign d2   = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        r_sqx <= dx2[2*COORD_W-1:0];
        r_sqy <= dy2[2*COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1  <= i_cmd.issue;
            r_v2  <= r_v1;
            r_hit <= r_v2 && (d2 < (2*COORD_W+1)'(r_join_dist_sq));
        end
    end

    // Cluster walk counters.
    always_comb begin
        n_cluster = r_cluster;
        n_k       = r_k;
        n_found   = r_found | r_hit;
        n_ccount  = r_ccount;
        if (i_cmd.load) begin
            n_cluster = '0;
            n_found   = 1'b0;
        end
        if (i_cmd.next) begin
            n_cluster = r_cluster + CC_W'(1);
            n_found   = 1'b0;
        end
        if (i_cmd.cnt_take) begin
            n_k = '0;
        end
        if (i_cmd.issue) begin
            n_k = r_k + SLOT_W'(1);
        end
        if (i_cmd.do_open) begin
            n_ccount = r_ccount + CC_W'(1);
        end
        if (i_cmd.do_clear) begin
            n_ccount = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_join_dist_sq <= JOIN_DIST_SQ_RESET;
            r_cluster      <= '0;
            r_k            <= '0;
            r_found        <= 1'b0;
            r_ccount       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_join_dist_sq <= i_cfg_wr_data;
            end
            r_cluster <= n_cluster;
            r_k       <= n_k;
            r_found   <= n_found;
            r_ccount  <= n_ccount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_px      <= i_point_x;
            r_py      <= i_point_y;
            r_tag     <= i_point_tag;
        end
        if (i_cmd.cnt_take) begin
            r_n <= cnt_rdata;
        end
    end

    // Result register.
    assign emit        = i_cmd.do_join | i_cmd.do_open | i_cmd.do_drop | i_cmd.do_clear;
    assign n_out_valid = emit | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_idx  <= (i_cmd.do_join | i_cmd.do_open) ? IDX_W'(r_cluster) : '0;
            r_out_slot <= i_cmd.do_join ? IDX_W'(join_slot) : '0;
            r_out_over <= i_cmd.do_join & join_full;
            priority if (i_cmd.do_join) begin
                r_out_outcome <= OUTC_JOINED;
            end else if (i_cmd.do_open) begin
                r_out_outcome <= OUTC_OPENED;
            end else if (i_cmd.do_drop) begin
                r_out_outcome <= OUTC_DROPPED;
            end else begin
                r_out_outcome <= OUTC_CLEARED;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cluster_index = r_out_idx;
    assign o_point_slot    = r_out_slot;
    assign o_outcome       = r_out_outcome;
    assign o_overwrote     = r_out_over;

    assign o_status.is_clear   = (r_command == CMD_CLEAR);
    assign o_status.c_end      = (r_cluster == r_ccount);
    assign o_status.table_full = (r_ccount == CC_W'(MAX_CLUSTERS));
    assign o_status.last_issue = ((CNT_W'(r_k) + CNT_W'(1)) == r_n);
    assign o_status.pipe_busy  = r_v1 | r_v2 | r_hit;
    assign o_status.found      = r_found;
    assign o_status.out_busy   = r_out_valid & ~i_out_ready;

    a_ccount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccount <= CC_W'(MAX_CLUSTERS))
        else $error("cluster count beyond the table size");

    a_open_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_open |-> (r_ccount < CC_W'(MAX_CLUSTERS)) && (r_cluster == r_ccount))
        else $error("cluster opened without room or away from the table end");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !(r_out_valid && !i_out_ready))
        else $error("result produced while the previous one is still held");

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> (CNT_W'(r_k) < r_n))
        else $error("point read beyond the cluster's fill");

endmodule

`default_nettype wire

### rtl/pca_ctrl.sv
// Controller of the point cluster assignment block: the state machine that walks
// the clusters and commands the datapath. Depends on pca_pkg.
`default_nettype none

module pca_ctrl import pca_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_CNT_WAIT = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_DRAIN    = 3'd4;
    localparam logic [2:0] S_JOIN     = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.is_clear || i_status.c_end) begin
                    if (!i_status.out_busy) begin
                        priority if (i_status.is_clear) begin
                            o_cmd.do_clear = 1'b1;
                        end else if (i_status.table_full) begin
                            o_cmd.do_drop = 1'b1;
                        end else begin
                            o_cmd.do_open = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.cnt_rd = 1'b1;
                    n_state      = S_CNT_WAIT;
                end
            end
            S_CNT_WAIT: begin
                o_cmd.cnt_take = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.found) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.issue = 1'b1;
                    if (i_status.last_issue) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    if (i_status.found) begin
                        n_state = S_JOIN;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = S_CHECK;
                    end
                end
            end
            S_JOIN: begin
                if (!i_status.out_busy) begin
                    o_cmd.do_join = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_join_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.do_join |-> i_status.found && !i_status.pipe_busy)
        else $error("join commanded without a settled near point");

    a_next_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.next |-> !i_status.found && !i_status.pipe_busy)
        else $error("moved past a cluster before its scan settled");

endmodule

`default_nettype wire
